// ===== sv/iss_pkg.sv =====
// Package for the insertion sorter: item types, cell link type and cell ops.
// No dependencies; used by iss_cell and insertion_sorter_unit.
package iss_pkg;

  localparam int unsigned DataW = 32;

  // Input item: one element of the set
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_in;
  } in_item_t;

  // Result item: one element of the sorted set
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_item_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] value;
    logic                    keep;   // holds a value not greater than the new item
  } iss_link_t;

  // Operation applied to every cell of the chain at once
  typedef enum logic [1:0] {
    OP_HOLD   = 2'b00,
    OP_INSERT = 2'b01,
    OP_SHIFT  = 2'b10
  } iss_op_e;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } iss_state_e;

endpackage

// ===== sv/insertion_sorter_unit.sv =====
// Insertion sorter: a chain of DEPTH cells sorts signed values as they arrive.
// One item is taken per cycle while idle and inserted in that cycle; if the
// chain is full it is dropped and overflow is set. After the last item, busy
// is high as the chain shifts out; results follow one per cycle, starting in
// the cycle after busy rises. The receiver cannot stall. Reset empties the
// chain and clears count and flag. Depends on iss_pkg and iss_cell.
module insertion_sorter_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  iss_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output iss_pkg::out_item_t result_o
);
  import iss_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  iss_state_e    state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;
  iss_op_e       op;
  logic          accept;
  logic          full;
  iss_link_t     links [DEPTH];

  assign busy   = (state_q == ST_DRAIN);
  assign accept = start && !busy;
  assign full   = (fill_q == CntW'(DEPTH));

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    iss_link_t lower, upper;
    if (i == 0) begin : g_first
      assign lower = '{valid: 1'b1, value: '0, keep: 1'b1};
    end else begin : g_mid
      assign lower = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_below_top
      assign upper = links[i+1];
    end
    iss_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .new_value_i (item_i.value),
      .lower_i     (lower),
      .upper_i     (upper),
      .link_o      (links[i])
    );
  end

  // Control: insert while idle, drain the chain after the last item
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    op          = OP_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            op     = OP_INSERT;
            fill_d = fill_q + CntW'(1);
          end
          if (item_i.last_in) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        op                 = OP_SHIFT;
        out_valid_d        = 1'b1;
        out_d.sorted_value = links[0].value;
        out_d.last_out     = (fill_q == CntW'(1));
        out_d.overflow     = ovf_q;
        fill_d             = fill_q - CntW'(1);
        if (fill_q == CntW'(1)) begin
          state_d = ST_IDLE;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

// ===== sv/iss_cell.sv =====
// One cell of the insertion chain: holds one sorted element and its valid bit.
// Depends on iss_pkg.
module iss_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  iss_pkg::iss_op_e           op_i,
  input  logic signed [iss_pkg::DataW-1:0] new_value_i,
  input  iss_pkg::iss_link_t         lower_i,   // neighbor below (smaller index)
  input  iss_pkg::iss_link_t         upper_i,   // neighbor above (larger index)
  output iss_pkg::iss_link_t         link_o
);
  import iss_pkg::*;

  logic             valid_q, valid_d;
  logic [DataW-1:0] value_q, value_d;
  logic             keep;

  // Stays put when it holds a value not greater than the new one
  assign keep = valid_q && !($signed(value_q) > new_value_i);

  assign link_o.valid = valid_q;
  assign link_o.value = value_q;
  assign link_o.keep  = keep;

  // Next value: insert, shift toward the output end, or hold
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    case (op_i)
      OP_INSERT: begin
        if (!keep) begin
          if (lower_i.keep) begin
            valid_d = 1'b1;
            value_d = new_value_i;
          end else begin
            valid_d = lower_i.valid;
            value_d = lower_i.value;
          end
        end
      end
      OP_SHIFT: begin
        valid_d = upper_i.valid;
        value_d = upper_i.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
